/* rtl/opvs_pkg.sv */
// Shared types, constants and decode functions for the OBD PID value scaler.
package opvs_pkg;

    localparam int OUT_W   = 37;   // width of the scaled value port
    localparam int NUM_W   = 24;   // signed numerator of a formula
    localparam int MAG_W   = 23;   // magnitude of the numerator
    localparam int ODD_W   = 8;    // odd factor of a denominator
    localparam int RECIP_W = 32;   // reciprocal width for constant division

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_RESPONSE  = 2'd1,
        ST_PID_MISMATCH = 2'd2,
        ST_UNKNOWN_PID  = 2'd3
    } status_t;

    // Scaling formula families of the live-data PIDs
    typedef enum logic [4:0] {
        FC_A,
        FC_A_PCT,
        FC_A_M40,
        FC_TRIM,
        FC_A_X3,
        FC_X_DIV4,
        FC_AM128_DIV2,
        FC_X_DIV100,
        FC_A_DIV200,
        FC_X,
        FC_X79_DIV1000,
        FC_X10,
        FC_X_DIV32768,
        FC_SX_DIV4,
        FC_XM400_DIV10,
        FC_X_DIV1000,
        FC_X_PCT,
        FC_X_DIV200,
        FC_SX,
        FC_XM26880_DIV128,
        FC_X_DIV20,
        FC_A_M125,
        FC_UNKNOWN
    } formula_t;

    // Odd part of a denominator; the power-of-two part is a shift
    typedef enum logic [2:0] {
        ODD_1,
        ODD_5,
        ODD_25,
        ODD_125,
        ODD_255
    } odd_t;

    // Stage enables of a two-stage constant divider
    typedef struct packed {
        logic est_en;
        logic fix_en;
    } div_ctrl_t;

    // Map a requested PID to its formula family
    function automatic formula_t pid_class(input logic [7:0] pid);
        formula_t fc;
        unique case (pid) inside
            8'h01, 8'h02, 8'h03, 8'h0B, 8'h0D, 8'h12, 8'h13, 8'h1C, 8'h1D,
            8'h1E, 8'h30, 8'h33, 8'h41, 8'h4F, 8'h50, 8'h51, 8'h5F:
                fc = FC_A;
            8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h47, 8'h48, 8'h49,
            8'h4A, 8'h4B, 8'h4C, 8'h52, 8'h5A, 8'h5B:
                fc = FC_A_PCT;
            8'h05, 8'h0F, 8'h46, 8'h5C:
                fc = FC_A_M40;
            8'h06, 8'h07, 8'h08, 8'h09, 8'h2D, 8'h55, 8'h56, 8'h57, 8'h58:
                fc = FC_TRIM;
            8'h0A: fc = FC_A_X3;
            8'h0C: fc = FC_X_DIV4;
            8'h0E: fc = FC_AM128_DIV2;
            8'h10: fc = FC_X_DIV100;
            8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B:
                fc = FC_A_DIV200;
            8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h63:
                fc = FC_X;
            8'h22: fc = FC_X79_DIV1000;
            8'h23, 8'h59: fc = FC_X10;
            8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h44:
                fc = FC_X_DIV32768;
            8'h32: fc = FC_SX_DIV4;
            8'h3C, 8'h3D, 8'h3E, 8'h3F: fc = FC_XM400_DIV10;
            8'h42: fc = FC_X_DIV1000;
            8'h43: fc = FC_X_PCT;
            8'h53: fc = FC_X_DIV200;
            8'h54: fc = FC_SX;
            8'h5D: fc = FC_XM26880_DIV128;
            8'h5E: fc = FC_X_DIV20;
            8'h61, 8'h62: fc = FC_A_M125;
            default: fc = FC_UNKNOWN;
        endcase
        return fc;
    endfunction

    // Odd factor value
    function automatic logic [ODD_W-1:0] odd_value(input odd_t code);
        logic [ODD_W-1:0] v;
        unique case (code)
            ODD_1:   v = 8'd1;
            ODD_5:   v = 8'd5;
            ODD_25:  v = 8'd25;
            ODD_125: v = 8'd125;
            ODD_255: v = 8'd255;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

    // floor((2^32 - 1) / m): the estimate is low by at most one
    function automatic logic [RECIP_W-1:0] odd_recip(input odd_t code);
        logic [RECIP_W-1:0] r;
        unique case (code)
            ODD_1:   r = 32'hFFFF_FFFF;
            ODD_5:   r = 32'h3333_3333;
            ODD_25:  r = 32'h0A3D_70A3;
            ODD_125: r = 32'h020C_49BA;
            ODD_255: r = 32'h0101_0101;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

/* rtl/opvs_const_div.sv */
// Two-stage divider by a small odd constant: reciprocal estimate, then correction.
module opvs_const_div #(
    parameter int DW = 23
) (
    input  logic                        clk,
    input  opvs_pkg::div_ctrl_t         ctrl,
    input  logic [DW-1:0]               dividend,
    input  opvs_pkg::odd_t              odd_sel,
    output logic [DW-1:0]               quotient,
    output logic [opvs_pkg::ODD_W-1:0]  remainder
);

    localparam int PW = DW + opvs_pkg::RECIP_W;
    localparam int BW = DW + opvs_pkg::ODD_W;

    logic [PW-1:0]               product;
    logic [DW-1:0]               estimate_next;
    logic [DW-1:0]               dividend_reg;
    opvs_pkg::odd_t              odd_reg;
    logic [DW-1:0]               estimate_reg;
    logic [BW-1:0]               back;
    logic [BW-1:0]               diff;
    logic [opvs_pkg::ODD_W:0]    residue;
    logic [opvs_pkg::ODD_W:0]    divisor;
    logic [DW-1:0]               quotient_next;
    logic [opvs_pkg::ODD_W-1:0]  remainder_next;
    logic [DW-1:0]               quotient_reg;
    logic [opvs_pkg::ODD_W-1:0]  remainder_reg;

    // Estimate the quotient by multiplying with the reciprocal
    assign product       = PW'(dividend) * PW'(opvs_pkg::odd_recip(odd_sel));
    assign estimate_next = product[PW-1:opvs_pkg::RECIP_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.est_en)
        begin
            dividend_reg <= dividend;
            odd_reg      <= odd_sel;
            estimate_reg <= estimate_next;
        end
    end

    // Correct the estimate by one where the remainder reaches the divisor
    always_comb
    begin
        divisor = {1'b0, opvs_pkg::odd_value(odd_reg)};
        back    = BW'(estimate_reg) * BW'(opvs_pkg::odd_value(odd_reg));
        diff    = BW'(dividend_reg) - back;
        residue = diff[opvs_pkg::ODD_W:0];
        if (residue >= divisor)
        begin
            quotient_next  = estimate_reg + DW'(1);
            remainder_next = opvs_pkg::ODD_W'(residue - divisor);
        end
        else
        begin
            quotient_next  = estimate_reg;
            remainder_next = residue[opvs_pkg::ODD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fix_en)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
        end
    end

    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule

/* rtl/obd_pid_value_scaler.sv */
// Top level of the OBD PID value scaler: seven-stage pipeline from frame to fixed point.
//
//  Channel  Direction  Handshake               Payload
//  input    in         in_valid / in_ready     request_pid .. frame_byte_7
//  output   out        out_valid / out_ready   scaled_value, result_status
//
//  An accepted transaction passes through stages 0 to 6 in order; the two constant
//  dividers are pipelined. One transaction is taken every cycle unless all stages hold.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  Each stage holds while the next one is full and stalled, so empty stages
//  keep filling while a result waits at the output.
module obd_pid_value_scaler #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           request_pid,
    input  logic                 service_select,
    input  logic [7:0]           frame_length,
    input  logic [7:0]           frame_byte_4,
    input  logic [7:0]           frame_byte_5,
    input  logic [7:0]           frame_byte_6,
    input  logic [7:0]           frame_byte_7,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [36:0]   scaled_value,
    output logic [1:0]           result_status
);

    localparam int NSTAGE = 7;
    localparam int WW     = opvs_pkg::ODD_W + FRACTION_BITS;
    localparam int S_W    = $clog2(FRACTION_BITS + 1);
    localparam int Q_W    = opvs_pkg::MAG_W + FRACTION_BITS + 1;
    localparam int NW     = opvs_pkg::NUM_W;
    localparam int MW     = opvs_pkg::MAG_W;
    localparam int OW     = opvs_pkg::OUT_W;
    localparam logic [Q_W-1:0] LIM_POS = {{(Q_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic [Q_W-1:0] LIM_NEG = LIM_POS + Q_W'(1);

    // Pipeline control
    logic [NSTAGE-1:0] stage_valid_reg;
    logic [NSTAGE-1:0] stage_valid_next;
    logic [NSTAGE-1:0] stage_ready;

    // Stage 0: byte selection and status
    opvs_pkg::formula_t s0_cls_next;
    logic [7:0]         s0_a_next;
    logic [7:0]         s0_b_next;
    opvs_pkg::status_t  s0_status_next;
    opvs_pkg::formula_t s0_cls_reg;
    logic [7:0]         s0_a_reg;
    logic [7:0]         s0_b_reg;
    opvs_pkg::status_t  s0_status_reg;

    // Stage 1: numerator and denominator split
    logic signed [NW-1:0] av;
    logic signed [NW-1:0] xv;
    logic signed [NW-1:0] sxv;
    logic signed [NW-1:0] num;
    logic [3:0]           pow_k;
    opvs_pkg::odd_t       s1_odd_next;
    logic [NW-1:0]        num_abs;
    logic [MW-1:0]        s1_mag_next;
    logic [S_W-1:0]       s1_shift_next;
    logic [MW-1:0]        s1_mag_reg;
    logic                 s1_neg_reg;
    opvs_pkg::odd_t       s1_odd_reg;
    logic [S_W-1:0]       s1_shift_reg;
    opvs_pkg::status_t    s1_status_reg;

    // Stages 2 and 3: first division, sideband
    logic                 s2_neg_reg;
    opvs_pkg::odd_t       s2_odd_reg;
    logic [S_W-1:0]       s2_shift_reg;
    opvs_pkg::status_t    s2_status_reg;
    logic                 s3_neg_reg;
    opvs_pkg::odd_t       s3_odd_reg;
    logic [S_W-1:0]       s3_shift_reg;
    opvs_pkg::status_t    s3_status_reg;
    opvs_pkg::div_ctrl_t  div1_ctrl;
    logic [MW-1:0]        q1;
    logic [opvs_pkg::ODD_W-1:0] r1;

    // Stages 4 and 5: second division, sideband
    logic [WW-1:0]        w_next;
    opvs_pkg::div_ctrl_t  div2_ctrl;
    logic [WW-1:0]        q2;
    logic [MW-1:0]        s4_q1_reg;
    logic                 s4_neg_reg;
    logic [S_W-1:0]       s4_shift_reg;
    opvs_pkg::status_t    s4_status_reg;
    logic [MW-1:0]        s5_q1_reg;
    logic                 s5_neg_reg;
    logic [S_W-1:0]       s5_shift_reg;
    opvs_pkg::status_t    s5_status_reg;

    // Stage 6: combine, saturate, sign
    logic [Q_W-1:0]       q_full;
    logic [Q_W-1:0]       q_sat;
    logic [OW-1:0]        mag_out;
    logic [OW-1:0]        out_value_next;
    logic [OW-1:0]        out_value_reg;
    opvs_pkg::status_t    out_status_reg;

    // Ready ripples back from the output; a stage loads whenever it is ready
    always_comb
    begin
        stage_ready[NSTAGE-1] = !stage_valid_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            stage_ready[i] = !stage_valid_reg[i] || stage_ready[i+1];
        end
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (stage_ready[i])
            begin
                stage_valid_next[i] = (i == 0) ? in_valid : stage_valid_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                stage_valid_next[i] = stage_valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign in_ready = stage_ready[0];

    // Pick data bytes A and B and settle the status
    always_comb
    begin
        s0_cls_next = opvs_pkg::pid_class(request_pid);
        if (service_select)
        begin
            s0_a_next = (frame_length >= 8'd8) ? frame_byte_6 : 8'd0;
            s0_b_next = (frame_length >= 8'd9) ? frame_byte_7 : 8'd0;
        end
        else
        begin
            s0_a_next = (frame_length >= 8'd7) ? frame_byte_5 : 8'd0;
            s0_b_next = (frame_length >= 8'd8) ? frame_byte_6 : 8'd0;
        end
        if (frame_length == 8'd0)
        begin
            s0_status_next = opvs_pkg::ST_NO_RESPONSE;
        end
        else if (frame_byte_4 != request_pid)
        begin
            s0_status_next = opvs_pkg::ST_PID_MISMATCH;
        end
        else if (s0_cls_next == opvs_pkg::FC_UNKNOWN)
        begin
            s0_status_next = opvs_pkg::ST_UNKNOWN_PID;
        end
        else
        begin
            s0_status_next = opvs_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s0_cls_reg    <= s0_cls_next;
            s0_a_reg      <= s0_a_next;
            s0_b_reg      <= s0_b_next;
            s0_status_reg <= s0_status_next;
        end
    end

    // Build the numerator; split the denominator into odd factor and shift
    always_comb
    begin
        av  = NW'({s0_a_reg});
        xv  = NW'({s0_a_reg, s0_b_reg});
        sxv = NW'(signed'({s0_a_reg, s0_b_reg}));
        num = '0;
        pow_k = 4'd0;
        s1_odd_next = opvs_pkg::ODD_1;
        unique case (s0_cls_reg)
            opvs_pkg::FC_A:          num = av;
            opvs_pkg::FC_A_PCT:
            begin
                num = av * 24'sd100;
                s1_odd_next = opvs_pkg::ODD_255;
            end
            opvs_pkg::FC_A_M40:      num = av - 24'sd40;
            opvs_pkg::FC_TRIM:
            begin
                num = av * 24'sd100 - 24'sd12800;
                pow_k = 4'd7;
            end
            opvs_pkg::FC_A_X3:       num = av * 24'sd3;
            opvs_pkg::FC_X_DIV4:
            begin
                num = xv;
                pow_k = 4'd2;
            end
            opvs_pkg::FC_AM128_DIV2:
            begin
                num = av - 24'sd128;
                pow_k = 4'd1;
            end
            opvs_pkg::FC_X_DIV100:
            begin
                num = xv;
                pow_k = 4'd2;
                s1_odd_next = opvs_pkg::ODD_25;
            end
            opvs_pkg::FC_A_DIV200:
            begin
                num = av;
                pow_k = 4'd3;
                s1_odd_next = opvs_pkg::ODD_25;
            end
            opvs_pkg::FC_X:          num = xv;
            opvs_pkg::FC_X79_DIV1000:
            begin
                num = xv * 24'sd79;
                pow_k = 4'd3;
                s1_odd_next = opvs_pkg::ODD_125;
            end
            opvs_pkg::FC_X10:        num = xv * 24'sd10;
            opvs_pkg::FC_X_DIV32768:
            begin
                num = xv;
                pow_k = 4'd15;
            end
            opvs_pkg::FC_SX_DIV4:
            begin
                num = sxv;
                pow_k = 4'd2;
            end
            opvs_pkg::FC_XM400_DIV10:
            begin
                num = xv - 24'sd400;
                pow_k = 4'd1;
                s1_odd_next = opvs_pkg::ODD_5;
            end
            opvs_pkg::FC_X_DIV1000:
            begin
                num = xv;
                pow_k = 4'd3;
                s1_odd_next = opvs_pkg::ODD_125;
            end
            opvs_pkg::FC_X_PCT:
            begin
                num = xv * 24'sd100;
                s1_odd_next = opvs_pkg::ODD_255;
            end
            opvs_pkg::FC_X_DIV200:
            begin
                num = xv;
                pow_k = 4'd3;
                s1_odd_next = opvs_pkg::ODD_25;
            end
            opvs_pkg::FC_SX:         num = sxv;
            opvs_pkg::FC_XM26880_DIV128:
            begin
                num = xv - 24'sd26880;
                pow_k = 4'd7;
            end
            opvs_pkg::FC_X_DIV20:
            begin
                num = xv;
                pow_k = 4'd2;
                s1_odd_next = opvs_pkg::ODD_5;
            end
            opvs_pkg::FC_A_M125:     num = av - 24'sd125;
            default:                 num = '0;
        endcase
        num_abs       = num[NW-1] ? NW'(-num) : NW'(num);
        s1_mag_next   = num_abs[MW-1:0];
        s1_shift_next = S_W'(FRACTION_BITS) - S_W'(pow_k);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            s1_mag_reg    <= s1_mag_next;
            s1_neg_reg    <= num[NW-1];
            s1_odd_reg    <= s1_odd_next;
            s1_shift_reg  <= s1_shift_next;
            s1_status_reg <= s0_status_reg;
        end
    end

    // Divide the magnitude by the odd factor: quotient and remainder
    assign div1_ctrl.est_en = stage_ready[2];
    assign div1_ctrl.fix_en = stage_ready[3];

    opvs_const_div #(
        .DW (MW)
    ) u_div_mag (
        .clk       (clk),
        .ctrl      (div1_ctrl),
        .dividend  (s1_mag_reg),
        .odd_sel   (s1_odd_reg),
        .quotient  (q1),
        .remainder (r1)
    );

    always_ff @(posedge clk)
    begin
        if (stage_ready[2])
        begin
            s2_neg_reg    <= s1_neg_reg;
            s2_odd_reg    <= s1_odd_reg;
            s2_shift_reg  <= s1_shift_reg;
            s2_status_reg <= s1_status_reg;
        end
        if (stage_ready[3])
        begin
            s3_neg_reg    <= s2_neg_reg;
            s3_odd_reg    <= s2_odd_reg;
            s3_shift_reg  <= s2_shift_reg;
            s3_status_reg <= s2_status_reg;
        end
    end

    // Scale the remainder and add half the odd factor for rounding
    assign w_next = (WW'(r1) << s3_shift_reg)
                  + WW'(opvs_pkg::odd_value(s3_odd_reg) >> 1);

    assign div2_ctrl.est_en = stage_ready[4];
    assign div2_ctrl.fix_en = stage_ready[5];

    opvs_const_div #(
        .DW (WW)
    ) u_div_frac (
        .clk       (clk),
        .ctrl      (div2_ctrl),
        .dividend  (w_next),
        .odd_sel   (s3_odd_reg),
        .quotient  (q2),
        .remainder ()
    );

    always_ff @(posedge clk)
    begin
        if (stage_ready[4])
        begin
            s4_q1_reg     <= q1;
            s4_neg_reg    <= s3_neg_reg;
            s4_shift_reg  <= s3_shift_reg;
            s4_status_reg <= s3_status_reg;
        end
        if (stage_ready[5])
        begin
            s5_q1_reg     <= s4_q1_reg;
            s5_neg_reg    <= s4_neg_reg;
            s5_shift_reg  <= s4_shift_reg;
            s5_status_reg <= s4_status_reg;
        end
    end

    // Combine both quotients, saturate to the output range, apply the sign
    always_comb
    begin
        q_full = (Q_W'(s5_q1_reg) << s5_shift_reg) + Q_W'(q2);
        if (s5_neg_reg)
        begin
            q_sat = (q_full > LIM_NEG) ? LIM_NEG : q_full;
        end
        else
        begin
            q_sat = (q_full > LIM_POS) ? LIM_POS : q_full;
        end
        mag_out = q_sat[OW-1:0];
        if (s5_status_reg != opvs_pkg::ST_OK)
        begin
            out_value_next = '0;
        end
        else if (s5_neg_reg)
        begin
            out_value_next = OW'(-mag_out);
        end
        else
        begin
            out_value_next = mag_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[6])
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= s5_status_reg;
        end
    end

    assign out_valid     = stage_valid_reg[NSTAGE-1];
    assign scaled_value  = signed'(out_value_reg);
    assign result_status = out_status_reg;

endmodule

/* rtl/opvs_checker.sv */
// Port-level checker for the OBD PID value scaler, bound to the top level.
module opvs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [36:0]  scaled_value,
    input logic [1:0]          result_status
);

    // Hold a stalled result transaction unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scaled_value)
            && $stable(result_status))
        else $error("stalled result transaction changed");

    // Drive zero on a valid result whenever the status is not ok
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_status != opvs_pkg::ST_OK) |-> scaled_value == 37'sd0)
        else $error("non-zero value with a failing status");

    // Drop every result while reset is held
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Accept input whenever the output stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    // Hold an offered input transaction until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input transaction withdrawn before acceptance");

endmodule

bind obd_pid_value_scaler opvs_checker u_opvs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .scaled_value  (scaled_value),
    .result_status (result_status)
);

/* verif/pid_scale_checker.sv */
// Checker for the OBD PID value scaler: predicts each scaled reading and compares results.
`timescale 1ns / 100ps
module pid_scale_checker #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [7:0]                         request_pid,
    input  logic                               service_select,
    input  logic [7:0]                         frame_length,
    input  logic [7:0]                         frame_byte_4,
    input  logic [7:0]                         frame_byte_5,
    input  logic [7:0]                         frame_byte_6,
    input  logic [7:0]                         frame_byte_7,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [opvs_pkg::OUT_W-1:0]  scaled_value,
    input  logic [1:0]                         result_status,
    output int                                 fail_count,
    output int                                 pending_count
);

    localparam int MAX_REPORTS = 10;
    localparam int OUT_W       = opvs_pkg::OUT_W;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        opvs_pkg::status_t       status;
    } reading_t;

    reading_t    expected_readings [$];
    reading_t    head_reading;
    int unsigned result_index;

    // Round num/den to fixed point, ties away from zero, saturated to the port range
    function automatic longint round_fixed(input longint num, input longint den);
        longint mag;
        longint q;
        longint lim_pos;
        longint lim_neg;
        lim_pos = (longint'(1) <<< (OUT_W - 1)) - 1;
        lim_neg = longint'(1) <<< (OUT_W - 1);
        mag = (num < 0) ? -num : num;
        q = (2 * (mag <<< FRACTION_BITS) + den) / (2 * den);
        if (num < 0)
            return (q > lim_neg) ? -lim_neg : -q;
        return (q > lim_pos) ? lim_pos : q;
    endfunction

    // Work out the reading that one received frame must produce
    function automatic reading_t scale_frame(
        input logic [7:0] pid,
        input logic       freeze,
        input logic [7:0] len,
        input logic [7:0] echo,
        input logic [7:0] b5,
        input logic [7:0] b6,
        input logic [7:0] b7
    );
        reading_t r;
        longint   a;
        longint   b;
        longint   x;
        longint   sx;
        longint   num;
        longint   den;
        longint   fixed_val;
        logic     known;

        // Pick data bytes; anything past the received length reads as zero
        if (freeze)
        begin
            a = (len >= 8'd8) ? longint'(b6) : 0;
            b = (len >= 8'd9) ? longint'(b7) : 0;
        end
        else
        begin
            a = (len >= 8'd7) ? longint'(b5) : 0;
            b = (len >= 8'd8) ? longint'(b6) : 0;
        end
        x  = a * 256 + b;
        sx = (x >= 32768) ? x - 65536 : x;

        num   = 0;
        den   = 1;
        known = 1'b1;
        case (pid)
            8'h01, 8'h02, 8'h03, 8'h0B, 8'h0D, 8'h12, 8'h13, 8'h1C, 8'h1D,
            8'h1E, 8'h30, 8'h33, 8'h41, 8'h4F, 8'h50, 8'h51, 8'h5F:
                num = a;
            8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h47, 8'h48, 8'h49,
            8'h4A, 8'h4B, 8'h4C, 8'h52, 8'h5A, 8'h5B:
            begin
                num = a * 100;
                den = 255;
            end
            8'h05, 8'h0F, 8'h46, 8'h5C:
                num = a - 40;
            8'h06, 8'h07, 8'h08, 8'h09, 8'h2D, 8'h55, 8'h56, 8'h57, 8'h58:
            begin
                num = a * 100 - 100 * 128;
                den = 128;
            end
            8'h0A:
                num = a * 3;
            8'h0C:
            begin
                num = x;
                den = 4;
            end
            8'h0E:
            begin
                num = a - 128;
                den = 2;
            end
            8'h10:
            begin
                num = x;
                den = 100;
            end
            8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B:
            begin
                num = a;
                den = 200;
            end
            8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h63:
                num = x;
            8'h22:
            begin
                num = x * 79;
                den = 1000;
            end
            // fuel rail gauge pressure and its sibling: ten kPa per count
            8'h23, 8'h59:
                num = x * 10;
            8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h44:
            begin
                num = x;
                den = 32768;
            end
            // signed vapour pressure
            8'h32:
            begin
                num = sx;
                den = 4;
            end
            8'h3C, 8'h3D, 8'h3E, 8'h3F:
            begin
                num = x - 400;
                den = 10;
            end
            8'h42:
            begin
                num = x;
                den = 1000;
            end
            8'h43:
            begin
                num = x * 100;
                den = 255;
            end
            8'h53:
            begin
                num = x;
                den = 200;
            end
            8'h54:
                num = sx;
            8'h5D:
            begin
                num = x - 210 * 128;
                den = 128;
            end
            8'h5E:
            begin
                num = x;
                den = 20;
            end
            8'h61, 8'h62:
                num = a - 125;
            default:
                known = 1'b0;
        endcase

        // Status in priority order; the value stays zero unless the status is ok
        r.value = '0;
        if (len == 8'd0)
            r.status = opvs_pkg::ST_NO_RESPONSE;
        else if (echo != pid)
            r.status = opvs_pkg::ST_PID_MISMATCH;
        else if (!known)
            r.status = opvs_pkg::ST_UNKNOWN_PID;
        else
        begin
            r.status  = opvs_pkg::ST_OK;
            fixed_val = round_fixed(num, den);
            r.value   = fixed_val[OUT_W-1:0];
        end
        return r;
    endfunction

    // Watch both channels: predict on each input transaction, compare on each output one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_readings.push_back(scale_frame(request_pid, service_select,
                    frame_length, frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7));

            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"result %0d arrived with no frame outstanding:",
                                  " value %0d status %0d"},
                                 result_index, scaled_value, result_status);
                end
                else
                begin
                    head_reading = expected_readings.pop_front();
                    if (head_reading.value !== scaled_value ||
                        head_reading.status !== result_status)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result %0d: expected value %0d status %0d,",
                                      " got value %0d status %0d"},
                                     result_index, head_reading.value, head_reading.status,
                                     scaled_value, result_status);
                    end
                end
                result_index++;
            end
            pending_count <= expected_readings.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// Top of the OBD PID value scaler testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam int FRAC_BITS    = 16;
    localparam int ITEM_TARGET  = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 17;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 420;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int FAMILY_COUNT = 22;

    localparam logic [7:0] PID_SUPPORTED_01_20 = 8'h00;
    localparam logic [7:0] PID_LAST_KNOWN      = 8'h63;
    localparam logic [7:0] PID_TOP             = 8'hFF;
    localparam logic [7:0] PID_INJECT_TIMING   = 8'h5D;

    // One PID from every scaling family
    localparam logic [FAMILY_COUNT*8-1:0] FAMILY_PIDS = {
        8'h01, 8'h04, 8'h05, 8'h06, 8'h0A, 8'h0C, 8'h0E, 8'h10, 8'h14, 8'h1F, 8'h22,
        8'h23, 8'h24, 8'h32, 8'h3C, 8'h42, 8'h43, 8'h53, 8'h54, 8'h5D, 8'h5E, 8'h61
    };

    typedef struct packed {
        logic [7:0] pid;
        logic       freeze;
        logic [7:0] len;
        logic [7:0] echo;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
    } frame_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [7:0]                         request_pid;
    logic                               service_select;
    logic [7:0]                         frame_length;
    logic [7:0]                         frame_byte_4;
    logic [7:0]                         frame_byte_5;
    logic [7:0]                         frame_byte_6;
    logic [7:0]                         frame_byte_7;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [opvs_pkg::OUT_W-1:0]  scaled_value;
    logic [1:0]                         result_status;
    int                                 fail_count;
    int                                 pending_count;
    int                                 sent_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    obd_pid_value_scaler #(
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .request_pid    (request_pid),
        .service_select (service_select),
        .frame_length   (frame_length),
        .frame_byte_4   (frame_byte_4),
        .frame_byte_5   (frame_byte_5),
        .frame_byte_6   (frame_byte_6),
        .frame_byte_7   (frame_byte_7),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scaled_value   (scaled_value),
        .result_status  (result_status)
    );

    pid_scale_checker #(
        .FRACTION_BITS (FRAC_BITS)
    ) scale_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .request_pid    (request_pid),
        .service_select (service_select),
        .frame_length   (frame_length),
        .frame_byte_4   (frame_byte_4),
        .frame_byte_5   (frame_byte_5),
        .frame_byte_6   (frame_byte_6),
        .frame_byte_7   (frame_byte_7),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scaled_value   (scaled_value),
        .result_status  (result_status),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // Both sides run without idling inside this stretch of frames
    function automatic bit calm_stretch();
        return sent_count >= CALM_FIRST && sent_count < CALM_LAST;
    endfunction

    // Well-formed frame of one scaling family, cycling through full and short frames
    function automatic frame_t family_frame(input int i);
        frame_t f;
        f.pid    = FAMILY_PIDS[i*8 +: 8];
        f.echo   = f.pid;
        f.freeze = i[0];
        // full live, full freeze, live missing B, freeze missing B
        f.len    = (i % 4 < 2) ? 8'd8 + 8'(i % 2) : 8'd7 + 8'(i % 2);
        f.b5     = 8'hFF;
        f.b6     = i[0] ? 8'h80 : 8'hFF;
        f.b7     = 8'hFF;
        return f;
    endfunction

    // Mostly well-formed frames with random data; the rest exercises each error path
    function automatic frame_t random_frame();
        frame_t f;
        int     kind;
        kind     = $urandom_range(0, 99);
        f.freeze = 1'($urandom_range(0, 1));
        f.b5     = 8'($urandom_range(0, 255));
        f.b6     = 8'($urandom_range(0, 255));
        f.b7     = 8'($urandom_range(0, 255));
        f.pid    = 8'($urandom_range(1, PID_LAST_KNOWN));
        f.len    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 10))
                                               : 8'($urandom_range(9, 255));
        f.echo   = f.pid;
        if (kind < 72)
            f.echo = f.pid;
        else if (kind < 80)
            f.len = 8'd0;
        else if (kind < 88)
            f.echo = f.pid ^ 8'($urandom_range(1, 255));
        else if (kind < 94)
        begin
            f.pid  = 8'($urandom_range(PID_LAST_KNOWN + 1, PID_TOP));
            f.echo = f.pid;
        end
        else
        begin
            f.pid  = 8'($urandom_range(0, 255));
            f.echo = 8'($urandom_range(0, 255));
            f.len  = 8'($urandom_range(0, 255));
        end
        return f;
    endfunction

    // Offer one frame, idling at random beforehand, and hold it until taken
    task automatic send_frame(input frame_t f);
        while (!calm_stretch() && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        request_pid    <= f.pid;
        service_select <= f.freeze;
        frame_length   <= f.len;
        frame_byte_4   <= f.echo;
        frame_byte_5   <= f.b5;
        frame_byte_6   <= f.b6;
        frame_byte_7   <= f.b7;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Result side: random back-pressure, a calm stretch and one long hold-off
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (calm_stretch())
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // End the run if it hangs
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : frame_source
        frame_t f;
        int     i;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        request_pid    <= '0;
        service_select <= 1'b0;
        frame_length   <= '0;
        frame_byte_4   <= '0;
        frame_byte_5   <= '0;
        frame_byte_6   <= '0;
        frame_byte_7   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Every scaling family once, with data bytes of FF or 80, full and short frames
        for (i = 0; i < FAMILY_COUNT; i++)
            send_frame(family_frame(i));

        // No response wins over a wrong echo
        f = family_frame(0);
        f.len  = 8'd0;
        f.echo = ~f.pid;
        send_frame(f);
        // Wrong echoed PID
        f = family_frame(1);
        f.echo = f.pid ^ 8'h80;
        send_frame(f);
        // Supported-PID bitmap is not scaled
        f = family_frame(0);
        f.pid  = PID_SUPPORTED_01_20;
        f.echo = f.pid;
        send_frame(f);
        // Highest PID with the longest frame
        f = family_frame(1);
        f.pid  = PID_TOP;
        f.echo = PID_TOP;
        f.len  = 8'hFF;
        send_frame(f);
        // Zero data: most negative injection timing
        f = family_frame(0);
        f.pid  = PID_INJECT_TIMING;
        f.echo = f.pid;
        f.b5   = 8'h00;
        f.b6   = 8'h00;
        send_frame(f);

        for (i = 0; i < ITEM_TARGET; i++)
            send_frame(random_frame());
        in_valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
